// ----- rtl/at_response_line_parser_unit_assert.svh -----
// Assertion macros for the parser's checker file.
`ifndef AT_RESPONSE_LINE_PARSER_UNIT_ASSERT_SVH
`define AT_RESPONSE_LINE_PARSER_UNIT_ASSERT_SVH

// Checked while out of reset.
`define ATRLP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("atrlp: property failed");

// Checked in and out of reset.
`define ATRLP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("atrlp: property failed");

`endif

// ----- rtl/atrlp_pkg.sv -----
package atrlp_pkg;

  // Default line buffer size: the line length count saturates at this value.
  localparam int unsigned LINE_BUF_SIZE_DEF = 32;

  // Only the first few characters of a line can ever match a result word.
  localparam int unsigned KEEP_CHARS = 5;
  localparam int unsigned KEEP_IDX_W = $clog2(KEEP_CHARS);

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] IDX_VERBOSE = '0;

  // Line terminators
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_BYTE  = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ERROR   = 3'd1,
    ST_READY   = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_TIMEOUT = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  data_byte;
    logic [7:0]  lines_expected;
    logic [15:0] capture_limit;
    logic [15:0] idle_timeout;
  } item_t;

  typedef struct packed {
    logic        done_res;
    status_e     status;
    logic        capture_valid;
    logic [7:0]  capture_byte;
    logic [15:0] capture_index;
    logic        busy_res;
  } result_t;

  typedef struct packed {
    logic    hit;
    status_e status;
  } match_t;

endpackage

// ----- rtl/atrlp_match.sv -----
// Compares the current line with the result words.
module atrlp_match #(
  parameter int unsigned LINE_BUF_SIZE = atrlp_pkg::LINE_BUF_SIZE_DEF
) (
  input  logic [atrlp_pkg::KEEP_CHARS-1:0][7:0]  chars_i,
  input  logic [$clog2(LINE_BUF_SIZE+1)-1:0]     len_i,
  input  logic                                   verbose_i,
  output atrlp_pkg::match_t                      match_o
);
  import atrlp_pkg::*;

  localparam int unsigned LenW = $clog2(LINE_BUF_SIZE + 1);

  logic is_ok_w, is_error_w, is_zero_w, is_four_w, is_ready_w;

  // Word compares; a length check guards each one
  assign is_ok_w    = (len_i == LenW'(2)) && (chars_i[0] == "O") && (chars_i[1] == "K");
  assign is_error_w = (len_i == LenW'(5)) && (chars_i[0] == "E") && (chars_i[1] == "R") &&
                      (chars_i[2] == "R") && (chars_i[3] == "O") && (chars_i[4] == "R");
  assign is_ready_w = (len_i == LenW'(5)) && (chars_i[0] == "R") && (chars_i[1] == "E") &&
                      (chars_i[2] == "A") && (chars_i[3] == "D") && (chars_i[4] == "Y");
  assign is_zero_w  = (len_i == LenW'(1)) && (chars_i[0] == "0");
  assign is_four_w  = (len_i == LenW'(1)) && (chars_i[0] == "4");

  // Mode words first, READY in both modes
  always_comb begin
    match_o = '{hit: 1'b0, status: ST_OK};
    priority if (verbose_i && is_ok_w) begin
      match_o = '{hit: 1'b1, status: ST_OK};
    end else if (verbose_i && is_error_w) begin
      match_o = '{hit: 1'b1, status: ST_ERROR};
    end else if (!verbose_i && is_zero_w) begin
      match_o = '{hit: 1'b1, status: ST_OK};
    end else if (!verbose_i && is_four_w) begin
      match_o = '{hit: 1'b1, status: ST_ERROR};
    end else if (is_ready_w) begin
      match_o = '{hit: 1'b1, status: ST_READY};
    end else begin
      match_o = '{hit: 1'b0, status: ST_OK};
    end
  end

endmodule

// ----- rtl/atrlp_core.sv -----
// Parser state and the per-item update.
module atrlp_core #(
  parameter int unsigned LINE_BUF_SIZE = atrlp_pkg::LINE_BUF_SIZE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  atrlp_pkg::item_t   item_i,
  input  logic               verbose_i,
  output atrlp_pkg::result_t result_o
);
  import atrlp_pkg::*;

  localparam int unsigned LenW = $clog2(LINE_BUF_SIZE + 1);

  logic                            active_q, active_d;
  logic [KEEP_CHARS-1:0][7:0]      chars_q;
  logic [LenW-1:0]                 len_q, len_d;
  logic [8:0]                      line_num_q, line_num_d;
  logic [15:0]                     text_q, text_d;
  logic [7:0]                      exp_q, exp_d;
  logic [15:0]                     cap_q, cap_d;
  logic [15:0]                     tmo_q, tmo_d;
  logic [15:0]                     idle_q, idle_d;

  logic       is_eol;
  logic       cap_ok;
  logic       char_wr;
  logic [8:0] line_num_inc;
  logic [15:0] idle_inc;
  match_t     match;

  atrlp_match #(
    .LINE_BUF_SIZE(LINE_BUF_SIZE)
  ) u_match (
    .chars_i  (chars_q),
    .len_i    (len_q),
    .verbose_i(verbose_i),
    .match_o  (match)
  );

  assign is_eol       = (item_i.data_byte == CHAR_CR) || (item_i.data_byte == CHAR_LF);
  assign line_num_inc = line_num_q + 9'd1;
  assign idle_inc     = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;
  assign cap_ok       = (cap_q != 16'd0) && (text_q < (cap_q - 16'd1)) &&
                        ((exp_q == 8'd1) || (line_num_q < {1'b0, exp_q}));

  // Next state and result
  always_comb begin
    active_d   = active_q;
    len_d      = len_q;
    line_num_d = line_num_q;
    text_d     = text_q;
    exp_d      = exp_q;
    cap_d      = cap_q;
    tmo_d      = tmo_q;
    idle_d     = idle_q;
    char_wr    = 1'b0;
    result_o   = '{done_res: 1'b0, status: ST_OK, capture_valid: 1'b0,
                   capture_byte: 8'd0, capture_index: 16'd0, busy_res: 1'b0};

    unique case (func_e'(item_i.func))
      FUNC_START: begin
        active_d   = 1'b1;
        len_d      = '0;
        line_num_d = 9'd1;
        text_d     = 16'd0;
        exp_d      = item_i.lines_expected;
        cap_d      = item_i.capture_limit;
        tmo_d      = item_i.idle_timeout;
        idle_d     = 16'd0;
      end
      FUNC_BYTE: begin
        if (active_q) begin
          idle_d = 16'd0;
          if (is_eol) begin
            // Empty lines are skipped
            if (len_q != '0) begin
              if (match.hit) begin
                result_o.done_res = 1'b1;
                result_o.status   = match.status;
                active_d          = 1'b0;
              end else begin
                line_num_d = line_num_inc;
                if (line_num_inc > {1'b0, exp_q}) begin
                  result_o.done_res = 1'b1;
                  result_o.status   = ST_UNKNOWN;
                  active_d          = 1'b0;
                end else begin
                  len_d = '0;
                end
              end
            end
          end else begin
            if (cap_ok) begin
              result_o.capture_valid = 1'b1;
              result_o.capture_byte  = item_i.data_byte;
              result_o.capture_index = text_q;
            end
            char_wr = (len_q < LenW'(KEEP_CHARS));
            if (len_q < LenW'(LINE_BUF_SIZE)) begin
              len_d = len_q + LenW'(1);
            end
            if (text_q != 16'hFFFF) begin
              text_d = text_q + 16'd1;
            end
          end
        end
      end
      FUNC_TICK: begin
        if (active_q) begin
          idle_d = idle_inc;
          if (idle_inc >= tmo_q) begin
            result_o.done_res = 1'b1;
            result_o.status   = ST_TIMEOUT;
            active_d          = 1'b0;
          end
        end
      end
      default: ;
    endcase

    result_o.busy_res = active_d;
  end

  // Control and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      len_q      <= '0;
      line_num_q <= 9'd1;
      text_q     <= 16'd0;
      exp_q      <= 8'd1;
      cap_q      <= 16'd0;
      tmo_q      <= 16'd0;
      idle_q     <= 16'd0;
    end else if (fire_i) begin
      active_q   <= active_d;
      len_q      <= len_d;
      line_num_q <= line_num_d;
      text_q     <= text_d;
      exp_q      <= exp_d;
      cap_q      <= cap_d;
      tmo_q      <= tmo_d;
      idle_q     <= idle_d;
    end
  end

  // Head of the line; later characters never take part in a match
  always_ff @(posedge clk_i) begin
    if (fire_i && char_wr) begin
      chars_q[len_q[KEEP_IDX_W-1:0]] <= item_i.data_byte;
    end
  end

endmodule

// ----- rtl/at_response_line_parser_unit.sv -----
// Channel   Dir  Transfer when             Contents
// s_axis    in   s_axis_tvalid&tready     tuser: func; tdata: byte, lines, capture, timeout
// m_axis    out  m_axis_tvalid&tready     tlast: done; tdata: status, capture, busy
// apb       in   psel&penable&pwrite      verbose_mode at byte address 0
//
// One item per cycle while results are taken; a result passes the input register, then
// the state update stage that loads the result register.
// The single state update stage sets the rate: each item sees the previous one's state.
// rst_ni clears all parser state asynchronously; the line head holds no reset.
// A stalled result holds in the output register; the input register takes one more
// item, then s_axis_tready drops until the result is taken.
module at_response_line_parser_unit #(
  parameter int unsigned LINE_BUF_SIZE = atrlp_pkg::LINE_BUF_SIZE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] data_byte, [15:8] lines_expected, [31:16] capture_limit, [47:32] idle_timeout
  input  logic [47:0]                      s_axis_tdata,
  // [1:0] func
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [2:0] status, [3] capture_valid, [11:4] capture_byte, [27:12] capture_index,
  // [28] busy_res, [31:29] zero
  output logic [31:0]                      m_axis_tdata,
  output logic                             m_axis_tlast,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [atrlp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import atrlp_pkg::*;

  logic    in_vld_q, in_vld_d;
  item_t   in_q;
  logic    out_vld_q, out_vld_d;
  result_t out_q;
  result_t result;
  logic    advance;
  logic    fire;
  logic    verbose_q;
  logic    reg_sel;

  // Pipeline flow
  assign advance       = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;
  assign in_vld_d      = s_axis_tready ? s_axis_tvalid : in_vld_q;
  assign out_vld_d     = advance ? in_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Input and result payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.func           <= s_axis_tuser;
      in_q.data_byte      <= s_axis_tdata[7:0];
      in_q.lines_expected <= s_axis_tdata[15:8];
      in_q.capture_limit  <= s_axis_tdata[31:16];
      in_q.idle_timeout   <= s_axis_tdata[47:32];
    end
    if (fire) begin
      out_q <= result;
    end
  end

  atrlp_core #(
    .LINE_BUF_SIZE(LINE_BUF_SIZE)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_q),
    .verbose_i(verbose_q),
    .result_o (result)
  );

  // Configuration register
  assign reg_sel = (paddr[APB_ADDR_W-1:2] == IDX_VERBOSE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {31'd0, verbose_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      verbose_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      verbose_q <= pwdata[0];
    end
  end

  // Result channel
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_q.done_res;
  assign m_axis_tdata  = {3'd0, out_q.busy_res, out_q.capture_index, out_q.capture_byte,
                          out_q.capture_valid, out_q.status};

endmodule

// ----- rtl/atrlp_checker.sv -----
`include "at_response_line_parser_unit_assert.svh"

// Port-level checks on the parser.
module atrlp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic        out_stall_w;
  logic [32:0] out_bus_w;

  assign out_stall_w = m_axis_tvalid && !m_axis_tready;
  assign out_bus_w   = {m_axis_tlast, m_axis_tdata};

  // Stalled result holds
  `ATRLP_ASSERT(a_out_hold, out_stall_w |=> m_axis_tvalid && $stable(out_bus_w))

  // A finishing result leaves the parser idle
  `ATRLP_ASSERT(a_done_idle, m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[28])

  // Status is zero unless the response finished
  `ATRLP_ASSERT(a_status_zero, m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[2:0] == 3'd0)

  // No captured text without the capture flag
  `ATRLP_ASSERT(a_capture_zero, m_axis_tvalid && !m_axis_tdata[3] |-> m_axis_tdata[27:4] == 24'd0)

  // Nothing offered while reset is held
  `ATRLP_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid)

endmodule

bind at_response_line_parser_unit atrlp_checker u_atrlp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
